// ----- src/rcsc_pkg.sv -----
// rcsc_pkg: shared types and constants for the RC stick conditioner.
// No dependencies; used by the interfaces, rcsc_chan and rc_stick_conditioner.
`timescale 1ns / 1ps
`default_nettype none

package rcsc_pkg;

    localparam int NUM_CH = 7;
    localparam int CH_THR = 0;
    localparam int CH_YAW = 1;
    localparam int CH_PIT = 2;
    localparam int CH_ROL = 3;
    localparam int CH_AX1 = 4;
    localparam int CH_AX2 = 5;
    localparam int CH_AX3 = 6;

    localparam int ADC_W  = 12;
    localparam int CHAN_W = 11;
    localparam int TRIM_W = 10;
    localparam int RAW_W  = 12;
    localparam int SQ_W   = 24;

    localparam logic [CHAN_W-1:0] CH_MIN = 11'd1000;
    localparam logic [CHAN_W-1:0] CH_MAX = 11'd2000;
    localparam logic [CHAN_W-1:0] CENTER = 11'd1500;
    localparam logic [CHAN_W-1:0] AUX_LO = 11'd1495;
    localparam logic [CHAN_W-1:0] AUX_HI = 11'd1505;
    localparam logic [SQ_W-1:0]   DEAD_SQ = 24'd625;

    typedef logic [ADC_W-1:0]  t_adc;
    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [RAW_W-1:0]  t_raw;
    typedef logic signed [TRIM_W-1:0] t_trim;

    typedef enum logic [2:0] {
        CFG_STICK_MODE   = 3'd0,
        CFG_OFS_THROTTLE = 3'd1,
        CFG_OFS_YAW      = 3'd2,
        CFG_OFS_PITCH    = 3'd3,
        CFG_OFS_ROLL     = 3'd4,
        CFG_OFS_AUX_ONE  = 3'd5,
        CFG_OFS_AUX_TWO  = 3'd6,
        CFG_OFS_AUX_THREE = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_adc adc_aux_two;
        t_adc adc_aux_one;
        t_adc adc_aux_three;
        t_adc adc_stick_up;
        t_adc adc_yaw;
        t_adc adc_roll;
        t_adc adc_stick_down;
    } t_in_item;

    typedef struct packed {
        t_chan filtered_throttle;
        t_chan filtered_yaw;
        t_chan filtered_pitch;
        t_chan filtered_roll;
        t_chan filtered_aux_one;
        t_chan filtered_aux_two;
        t_chan filtered_aux_three;
    } t_out_item;

    // load: sample transfer into the running sums; adv: sums move to the average stage
    typedef struct packed {
        logic load;
        logic adv;
    } t_pipe_ctl;

endpackage

`default_nettype wire

// ----- src/rcsc_if.sv -----
// rcsc_in_if / rcsc_out_if: valid/ready channels for sample and result items.
// Depends on rcsc_pkg for the payload structs.
`timescale 1ns / 1ps
`default_nettype none

interface rcsc_in_if;
    logic               valid;
    logic               ready;
    rcsc_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rcsc_out_if;
    logic                valid;
    logic                ready;
    rcsc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/rcsc_chan.sv -----
// rcsc_chan: one channel's trim, limit, history shift line, running sum and
// divide-by-window. Depends on rcsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcsc_chan #(
    parameter int WINDOW_LEN = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire rcsc_pkg::t_pipe_ctl i_ctl,
    input  wire rcsc_pkg::t_raw      i_raw,
    input  wire rcsc_pkg::t_trim     i_trim,
    output rcsc_pkg::t_chan          o_avg
);

    localparam int SUM_W  = $clog2(WINDOW_LEN * 2000 + 1);
    localparam int WL_B   = $clog2(WINDOW_LEN);
    localparam int SHIFT  = SUM_W + WL_B;
    localparam int RCP_W  = SHIFT + 1;
    localparam longint RECIP = ((longint'(1) << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam int DIFF_W = rcsc_pkg::RAW_W + 2;

    rcsc_pkg::t_chan r_hist [WINDOW_LEN];
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    rcsc_pkg::t_chan  r_avg;

    logic signed [DIFF_W-1:0] w_diff;
    rcsc_pkg::t_chan          w_lim;
    logic [PROD_W-1:0]        w_prod;

    assign w_diff = $signed({2'b00, i_raw})
                  - $signed({{(DIFF_W-rcsc_pkg::TRIM_W){i_trim[rcsc_pkg::TRIM_W-1]}}, i_trim});

    always_comb begin
        if (w_diff <= $signed({3'b000, rcsc_pkg::CH_MIN})) begin
            w_lim = rcsc_pkg::CH_MIN;
        end else if (w_diff >= $signed({3'b000, rcsc_pkg::CH_MAX})) begin
            w_lim = rcsc_pkg::CH_MAX;
        end else begin
            w_lim = w_diff[rcsc_pkg::CHAN_W-1:0];
        end
    end

    // oldest entry leaves the window as the new one enters
    assign n_sum = r_sum - SUM_W'(r_hist[WINDOW_LEN-1]) + SUM_W'(w_lim);

    // floor(sum / WINDOW_LEN) by reciprocal multiply, exact for all sums in range
    assign w_prod = PROD_W'(r_sum) * PROD_W'(RCP_W'(RECIP));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_ctl.load) begin
            r_sum     <= n_sum;
            r_hist[0] <= w_lim;
            for (int i = 1; i < WINDOW_LEN; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_avg <= w_prod[SHIFT +: rcsc_pkg::CHAN_W];
        end
    end

    assign o_avg = r_avg;

endmodule

`default_nettype wire

// ----- src/rc_stick_conditioner.sv -----
// rc_stick_conditioner: top level. Channel mapping, trim registers, pipeline
// control and the center deadbands. Depends on rcsc_pkg, rcsc_if, rcsc_chan.
//
// Takes one sample transfer per clock while the output is not stalled, and
// delivers one result transfer per sample. A result reaches the output in stages:
// the running sums update at the input transfer, the window average
// is formed by a reciprocal multiply in the next stage, and the squared-distance
// deadbands feed the output register. Each stage holds only while the one after
// it is full and stalled, so while a result waits the input keeps taking samples
// only until the earlier stages are full. Writes to the configuration port take
// effect at once and are meant for times when the pipeline is empty.
// WINDOW_LEN (1..16) sets the depth of the averaging window.
`timescale 1ns / 1ps
`default_nettype none

module rc_stick_conditioner #(
    parameter int WINDOW_LEN = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rcsc_in_if.sink          i_in,
    rcsc_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [9:0]  i_cfg_data
);

    logic            r_stick_mode;
    rcsc_pkg::t_trim r_trim [rcsc_pkg::NUM_CH];

    logic r_v1;
    logic r_v2;
    logic r_ov;
    rcsc_pkg::t_out_item r_out;

    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;
    logic w_adv3;
    rcsc_pkg::t_pipe_ctl w_ctl;

    logic [9:0] w_up;
    logic [9:0] w_down;
    rcsc_pkg::t_raw w_up_raw;
    rcsc_pkg::t_raw w_down_raw;
    rcsc_pkg::t_raw w_raw [rcsc_pkg::NUM_CH];
    rcsc_pkg::t_chan w_avg [rcsc_pkg::NUM_CH];

    logic w_dead_ty;
    logic w_dead_pr;
    rcsc_pkg::t_out_item n_out;

    function automatic rcsc_pkg::t_raw add_raw(input rcsc_pkg::t_adc s);
        add_raw = {1'b0, rcsc_pkg::CH_MIN} + {2'b00, s[rcsc_pkg::ADC_W-1:2]};
    endfunction

    function automatic rcsc_pkg::t_raw sub_raw(input rcsc_pkg::t_adc s);
        sub_raw = {1'b0, rcsc_pkg::CH_MAX} - {2'b00, s[rcsc_pkg::ADC_W-1:2]};
    endfunction

    function automatic logic [rcsc_pkg::SQ_W-1:0] sq_dist(input rcsc_pkg::t_chan a,
                                                          input rcsc_pkg::t_chan b);
        logic signed [rcsc_pkg::CHAN_W:0] da;
        logic signed [rcsc_pkg::CHAN_W:0] db;
        logic signed [rcsc_pkg::SQ_W-1:0] pa;
        logic signed [rcsc_pkg::SQ_W-1:0] pb;
        da = $signed({1'b0, a}) - $signed({1'b0, rcsc_pkg::CENTER});
        db = $signed({1'b0, b}) - $signed({1'b0, rcsc_pkg::CENTER});
        pa = da * da;
        pb = db * db;
        sq_dist = $unsigned(pa) + $unsigned(pb);
    endfunction

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stick_mode <= 1'b0;
            for (int i = 0; i < rcsc_pkg::NUM_CH; i++) begin
                r_trim[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (rcsc_pkg::t_cfg_idx'(i_cfg_idx))
                rcsc_pkg::CFG_STICK_MODE:    r_stick_mode <= i_cfg_data[0];
                rcsc_pkg::CFG_OFS_THROTTLE:  r_trim[rcsc_pkg::CH_THR] <= $signed(i_cfg_data);
                rcsc_pkg::CFG_OFS_YAW:       r_trim[rcsc_pkg::CH_YAW] <= $signed(i_cfg_data);
                rcsc_pkg::CFG_OFS_PITCH:     r_trim[rcsc_pkg::CH_PIT] <= $signed(i_cfg_data);
                rcsc_pkg::CFG_OFS_ROLL:      r_trim[rcsc_pkg::CH_ROL] <= $signed(i_cfg_data);
                rcsc_pkg::CFG_OFS_AUX_ONE:   r_trim[rcsc_pkg::CH_AX1] <= $signed(i_cfg_data);
                rcsc_pkg::CFG_OFS_AUX_TWO:   r_trim[rcsc_pkg::CH_AX2] <= $signed(i_cfg_data);
                rcsc_pkg::CFG_OFS_AUX_THREE: r_trim[rcsc_pkg::CH_AX3] <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // pipeline handshake
    assign w_rdy3 = !r_ov || o_out.ready;
    assign w_adv3 = r_v2 && w_rdy3;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_ctl.load = i_in.valid && w_rdy1;
    assign w_ctl.adv  = r_v1 && w_rdy2;
    assign i_in.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_ctl.load) begin
                r_v1 <= 1'b1;
            end else if (w_ctl.adv) begin
                r_v1 <= 1'b0;
            end
            if (w_ctl.adv) begin
                r_v2 <= 1'b1;
            end else if (w_adv3) begin
                r_v2 <= 1'b0;
            end
            if (w_adv3) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // channel mapping
    assign w_up       = i_in.data.adc_stick_up[rcsc_pkg::ADC_W-1:2];
    assign w_down     = i_in.data.adc_stick_down[rcsc_pkg::ADC_W-1:2];
    assign w_up_raw   = {1'b0, rcsc_pkg::CH_MIN} + {2'b00, w_up};
    assign w_down_raw = {1'b0, rcsc_pkg::CH_MAX} - {2'b00, w_down};

    assign w_raw[rcsc_pkg::CH_THR] = r_stick_mode ? w_up_raw : w_down_raw;
    assign w_raw[rcsc_pkg::CH_PIT] = r_stick_mode ? w_down_raw : w_up_raw;
    assign w_raw[rcsc_pkg::CH_YAW] = add_raw(i_in.data.adc_yaw);
    assign w_raw[rcsc_pkg::CH_ROL] = sub_raw(i_in.data.adc_roll);
    assign w_raw[rcsc_pkg::CH_AX1] = add_raw(i_in.data.adc_aux_one);
    assign w_raw[rcsc_pkg::CH_AX2] = add_raw(i_in.data.adc_aux_two);
    assign w_raw[rcsc_pkg::CH_AX3] = add_raw(i_in.data.adc_aux_three);

    for (genvar c = 0; c < rcsc_pkg::NUM_CH; c++) begin : g_chan
        rcsc_chan #(
            .WINDOW_LEN (WINDOW_LEN)
        ) u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_raw   (w_raw[c]),
            .i_trim  (r_trim[c]),
            .o_avg   (w_avg[c])
        );
    end

    // center deadbands
    assign w_dead_ty = sq_dist(w_avg[rcsc_pkg::CH_THR], w_avg[rcsc_pkg::CH_YAW])
                       <= rcsc_pkg::DEAD_SQ;
    assign w_dead_pr = sq_dist(w_avg[rcsc_pkg::CH_ROL], w_avg[rcsc_pkg::CH_PIT])
                       <= rcsc_pkg::DEAD_SQ;

    always_comb begin
        n_out.filtered_throttle = w_dead_ty ? rcsc_pkg::CENTER : w_avg[rcsc_pkg::CH_THR];
        n_out.filtered_yaw      = w_dead_ty ? rcsc_pkg::CENTER : w_avg[rcsc_pkg::CH_YAW];
        n_out.filtered_pitch    = w_dead_pr ? rcsc_pkg::CENTER : w_avg[rcsc_pkg::CH_PIT];
        n_out.filtered_roll     = w_dead_pr ? rcsc_pkg::CENTER : w_avg[rcsc_pkg::CH_ROL];
        n_out.filtered_aux_two  = w_avg[rcsc_pkg::CH_AX2];
        n_out.filtered_aux_one  = w_avg[rcsc_pkg::CH_AX1];
        n_out.filtered_aux_three = w_avg[rcsc_pkg::CH_AX3];
        if (w_avg[rcsc_pkg::CH_AX1] > rcsc_pkg::AUX_LO
                && w_avg[rcsc_pkg::CH_AX1] < rcsc_pkg::AUX_HI) begin
            n_out.filtered_aux_one = rcsc_pkg::CENTER;
        end
        if (w_avg[rcsc_pkg::CH_AX3] > rcsc_pkg::AUX_LO
                && w_avg[rcsc_pkg::CH_AX3] < rcsc_pkg::AUX_HI) begin
            n_out.filtered_aux_three = rcsc_pkg::CENTER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    // checks
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && !r_v1 && !r_v2)
        else $error("pipeline not empty after reset");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.filtered_throttle <= rcsc_pkg::CH_MAX
                     && o_out.data.filtered_roll <= rcsc_pkg::CH_MAX
                     && o_out.data.filtered_aux_two <= rcsc_pkg::CH_MAX)
        else $error("filtered value above limit");

    a_aux_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.data.filtered_aux_one > rcsc_pkg::AUX_LO
                          && o_out.data.filtered_aux_one < rcsc_pkg::AUX_HI
                          && o_out.data.filtered_aux_one != rcsc_pkg::CENTER))
        else $error("aux one deadband not applied");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !o_out.valid |=> o_out.valid)
        else $error("averaged item did not reach the output register");

    a_load_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_v1)
        else $error("transfer did not enter the sum stage");

endmodule

`default_nettype wire

// ----- test/rc_stick_conditioner_test.sv -----
// rc_stick_conditioner_test: self-checking bench for the stick conditioner; predicts every
// result transfer from the accepted samples and the trim/mode registers, with random stalls.
// Depends on rcsc_pkg, rcsc_if and rc_stick_conditioner.
`timescale 1ns / 1ps

module rc_stick_conditioner_test;
    import rcsc_pkg::*;

    localparam int WINDOW = 5;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       src_valid = 1'b0;
    t_in_item   src_data  = '0;
    logic       sink_ready = 1'b0;
    logic       cfg_we   = 1'b0;
    t_cfg_idx   cfg_idx  = CFG_STICK_MODE;
    logic [9:0] cfg_data = '0;

    rcsc_in_if  sample_if ();
    rcsc_out_if result_if ();

    assign sample_if.valid = src_valid;
    assign sample_if.data  = src_data;
    assign result_if.ready = sink_ready;

    rc_stick_conditioner #(.WINDOW_LEN(WINDOW)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (sample_if),
        .o_out      (result_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // predictor state
    logic        mode_reg;
    t_trim       trim_reg [NUM_CH];
    t_chan       window_hist [NUM_CH][WINDOW];
    logic [14:0] window_sum [NUM_CH];
    int          window_pos;

    t_in_item  sample_backlog [$];
    t_out_item expected_channels [$];
    int        mismatches = 0;
    logic      sample_taken = 1'b0;
    bit        calm = 1'b0;
    bit        long_hold = 1'b0;
    bit        long_hold_done = 1'b0;

    function automatic t_cfg_idx trim_index(int c);
        case (c)
            CH_THR: return CFG_OFS_THROTTLE;
            CH_YAW: return CFG_OFS_YAW;
            CH_PIT: return CFG_OFS_PITCH;
            CH_ROL: return CFG_OFS_ROLL;
            CH_AX1: return CFG_OFS_AUX_ONE;
            CH_AX2: return CFG_OFS_AUX_TWO;
            default: return CFG_OFS_AUX_THREE;
        endcase
    endfunction

    function automatic int quarter_of(t_adc a);
        return int'(a[ADC_W-1:2]);
    endfunction

    function automatic int center_dist2(int a, int b);
        int da;
        int db;
        da = a - int'(CENTER);
        db = b - int'(CENTER);
        return da * da + db * db;
    endfunction

    function automatic t_out_item condition_sticks(t_in_item s);
        int        level [NUM_CH];
        int        avg [NUM_CH];
        int        v;
        t_out_item r;
        if (mode_reg) begin
            level[CH_THR] = 1000 + quarter_of(s.adc_stick_up);
            level[CH_PIT] = 2000 - quarter_of(s.adc_stick_down);
        end else begin
            level[CH_THR] = 2000 - quarter_of(s.adc_stick_down);
            level[CH_PIT] = 1000 + quarter_of(s.adc_stick_up);
        end
        level[CH_YAW] = 1000 + quarter_of(s.adc_yaw);
        level[CH_ROL] = 2000 - quarter_of(s.adc_roll);
        level[CH_AX1] = 1000 + quarter_of(s.adc_aux_one);
        level[CH_AX2] = 1000 + quarter_of(s.adc_aux_two);
        level[CH_AX3] = 1000 + quarter_of(s.adc_aux_three);
        for (int c = 0; c < NUM_CH; c++) begin
            v = level[c] - int'(trim_reg[c]);
            if (v < int'(CH_MIN)) v = int'(CH_MIN);
            else if (v > int'(CH_MAX)) v = int'(CH_MAX);
            window_sum[c] = window_sum[c] - window_hist[c][window_pos] + v;
            window_hist[c][window_pos] = t_chan'(v);
            avg[c] = int'(window_sum[c]) / WINDOW;
        end
        window_pos = (window_pos + 1) % WINDOW;
        if (center_dist2(avg[CH_THR], avg[CH_YAW]) <= int'(DEAD_SQ)) begin
            avg[CH_THR] = int'(CENTER);
            avg[CH_YAW] = int'(CENTER);
        end
        if (center_dist2(avg[CH_ROL], avg[CH_PIT]) <= int'(DEAD_SQ)) begin
            avg[CH_ROL] = int'(CENTER);
            avg[CH_PIT] = int'(CENTER);
        end
        if (avg[CH_AX1] > int'(AUX_LO) && avg[CH_AX1] < int'(AUX_HI)) avg[CH_AX1] = int'(CENTER);
        if (avg[CH_AX3] > int'(AUX_LO) && avg[CH_AX3] < int'(AUX_HI)) avg[CH_AX3] = int'(CENTER);
        r.filtered_throttle  = t_chan'(avg[CH_THR]);
        r.filtered_yaw       = t_chan'(avg[CH_YAW]);
        r.filtered_pitch     = t_chan'(avg[CH_PIT]);
        r.filtered_roll      = t_chan'(avg[CH_ROL]);
        r.filtered_aux_one   = t_chan'(avg[CH_AX1]);
        r.filtered_aux_two   = t_chan'(avg[CH_AX2]);
        r.filtered_aux_three = t_chan'(avg[CH_AX3]);
        return r;
    endfunction

    function automatic void check_field(string label, t_chan want, t_chan got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t %s: expected %0d, got %0d", $realtime, label, want, got);
        end
    endfunction

    // monitor: register writes, result checks, sample prediction
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            mode_reg   = 1'b0;
            window_pos = 0;
            for (int c = 0; c < NUM_CH; c++) begin
                trim_reg[c]   = '0;
                window_sum[c] = '0;
                for (int k = 0; k < WINDOW; k++) window_hist[c][k] = '0;
            end
            sample_taken <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_STICK_MODE) mode_reg = cfg_data[0];
                for (int c = 0; c < NUM_CH; c++)
                    if (cfg_idx == trim_index(c)) trim_reg[c] = $signed(cfg_data);
            end
            if (result_if.valid && result_if.ready) begin
                got = result_if.data;
                if (expected_channels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t unexpected result transfer %h", $realtime, got);
                end else begin
                    want = expected_channels.pop_front();
                    check_field("throttle",  want.filtered_throttle,  got.filtered_throttle);
                    check_field("yaw",       want.filtered_yaw,       got.filtered_yaw);
                    check_field("pitch",     want.filtered_pitch,     got.filtered_pitch);
                    check_field("roll",      want.filtered_roll,      got.filtered_roll);
                    check_field("aux_one",   want.filtered_aux_one,   got.filtered_aux_one);
                    check_field("aux_two",   want.filtered_aux_two,   got.filtered_aux_two);
                    check_field("aux_three", want.filtered_aux_three, got.filtered_aux_three);
                end
            end
            if (sample_if.valid && sample_if.ready)
                expected_channels.push_back(condition_sticks(sample_if.data));
            sample_taken <= sample_if.valid && sample_if.ready;
        end
    end

    // sample driver
    int src_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            src_valid <= 1'b0;
        end else if (!src_valid || sample_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                src_valid <= 1'b0;
            end else if (sample_backlog.size() > 0) begin
                src_data  <= sample_backlog.pop_front();
                src_valid <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 10);
            end else begin
                src_valid <= 1'b0;
            end
        end
    end

    // result sink
    int sink_gap = 0;
    int hold_cycles = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else if (long_hold && !long_hold_done) begin
            sink_ready <= 1'b0;
            hold_cycles++;
            if (hold_cycles >= 80) long_hold_done = 1'b1;
        end else if (calm) begin
            sink_ready <= 1'b1;
        end else if (sink_gap > 0) begin
            sink_gap--;
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 10);
        end
    end

    function automatic t_adc nudge(t_adc a);
        int x;
        x = int'(a) + int'($urandom_range(0, 8)) - 4;
        if (x < 0) x = 0;
        if (x > 4095) x = 4095;
        return t_adc'(x);
    endfunction

    // sample that lands a channel near 1500 under the current trims
    function automatic t_adc near_center(bit adding, t_trim trim);
        int q;
        q = (adding ? 500 + int'(trim) : 500 - int'(trim)) + int'($urandom_range(0, 28)) - 14;
        if (q < 0) q = 0;
        if (q > 1023) q = 1023;
        return t_adc'(q * 4 + int'($urandom_range(0, 3)));
    endfunction

    function automatic t_in_item random_sample();
        t_in_item s;
        s.adc_aux_two    = t_adc'($urandom_range(0, 4095));
        s.adc_aux_one    = t_adc'($urandom_range(0, 4095));
        s.adc_aux_three  = t_adc'($urandom_range(0, 4095));
        s.adc_stick_up   = t_adc'($urandom_range(0, 4095));
        s.adc_yaw        = t_adc'($urandom_range(0, 4095));
        s.adc_roll       = t_adc'($urandom_range(0, 4095));
        s.adc_stick_down = t_adc'($urandom_range(0, 4095));
        return s;
    endfunction

    function automatic t_in_item centered_sample();
        t_in_item s;
        s.adc_aux_two    = near_center(1'b1, trim_reg[CH_AX2]);
        s.adc_aux_one    = near_center(1'b1, trim_reg[CH_AX1]);
        s.adc_aux_three  = near_center(1'b1, trim_reg[CH_AX3]);
        s.adc_stick_up   = near_center(1'b1, mode_reg ? trim_reg[CH_THR] : trim_reg[CH_PIT]);
        s.adc_yaw        = near_center(1'b1, trim_reg[CH_YAW]);
        s.adc_roll       = near_center(1'b0, trim_reg[CH_ROL]);
        s.adc_stick_down = near_center(1'b0, mode_reg ? trim_reg[CH_PIT] : trim_reg[CH_THR]);
        return s;
    endfunction

    function automatic t_in_item jitter(t_in_item b);
        t_in_item s;
        s.adc_aux_two    = nudge(b.adc_aux_two);
        s.adc_aux_one    = nudge(b.adc_aux_one);
        s.adc_aux_three  = nudge(b.adc_aux_three);
        s.adc_stick_up   = nudge(b.adc_stick_up);
        s.adc_yaw        = nudge(b.adc_yaw);
        s.adc_roll       = nudge(b.adc_roll);
        s.adc_stick_down = nudge(b.adc_stick_down);
        return s;
    endfunction

    // steady runs near center settle the windows close to 1500, around the aux snap band edges
    task automatic queue_random(int count);
        t_in_item base;
        int left;
        int run_len;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 9) < 3) begin
                sample_backlog.push_back(random_sample());
                left--;
            end else begin
                base    = centered_sample();
                run_len = $urandom_range(5, 12);
                for (int k = 0; k < run_len && left > 0; k++) begin
                    if ($urandom_range(0, 15) == 0) sample_backlog.push_back(random_sample());
                    else sample_backlog.push_back(jitter(base));
                    left--;
                end
            end
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [9:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_settings(bit mode, int lo, int hi);
        int v;
        write_reg(CFG_STICK_MODE, {9'd0, mode});
        for (int c = 0; c < NUM_CH; c++) begin
            v = lo + int'($urandom_range(0, hi - lo));
            write_reg(trim_index(c), v[9:0]);
        end
        @(posedge i_clk);
    endtask

    task automatic settle();
        while (sample_backlog.size() != 0 || src_valid || expected_channels.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic run_phase(bit mode, int lo, int hi, int count);
        settle();
        load_settings(mode, lo, hi);
        queue_random(count);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_settings(1'b0, 0, 0);
        sample_backlog.push_back('{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0});
        sample_backlog.push_back('{12'd4095, 12'd4095, 12'd4095, 12'd4095,
                                   12'd4095, 12'd4095, 12'd4095});
        sample_backlog.push_back('{12'hAAA, 12'h555, 12'hAAA, 12'h555,
                                   12'hAAA, 12'h555, 12'hAAA});
        sample_backlog.push_back('{12'h555, 12'hAAA, 12'h555, 12'hAAA,
                                   12'h555, 12'hAAA, 12'h555});
        // squared distance exactly 625 on both pairs, aux just inside the snap band
        repeat (6)
            sample_backlog.push_back('{12'd2000, 12'd1984, 12'd2016, 12'd2060,
                                       12'd2100, 12'd1920, 12'd2000});
        // just outside the deadbands
        repeat (6)
            sample_backlog.push_back('{12'd2000, 12'd1980, 12'd2020, 12'd2064,
                                       12'd2104, 12'd1920, 12'd2000});

        run_phase(1'b1, -512, -512, 200);
        run_phase(1'b0, 511, 511, 200);
        long_hold = 1'b1;
        while (!long_hold_done) @(posedge i_clk);
        long_hold = 1'b0;
        run_phase(1'b1, -512, 511, 220);
        run_phase(1'b0, -512, 511, 220);
        run_phase(1'b0, -40, 40, 200);
        settle();
        calm = 1'b1;
        run_phase(1'b1, 0, 0, 200);

        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- rc_stick_conditioner.f -----
src/rcsc_pkg.sv
src/rcsc_if.sv
src/rcsc_chan.sv
src/rc_stick_conditioner.sv
test/rc_stick_conditioner_test.sv
